/* rtl/csgl_pkg.sv */
// ----------------------------------------------------------------------------
// csgl_pkg: shared types and constants for the cmap segment glyph lookup
// Request and status codes, register indexes, field widths and the
// segment record held in the segment store.
// ----------------------------------------------------------------------------
package csgl_pkg;

  // fixed field widths
  localparam int unsigned CODE_W       = 16;
  localparam int unsigned ENTRY_W      = 12;
  localparam int unsigned SEG_COUNT_W  = 9;
  localparam int unsigned WORD_COUNT_W = 13;
  localparam int unsigned SEG_NUM_W    = 8;
  localparam int unsigned CFG_DATA_W   = 13;
  // signed word index: segment + offset/2 + (code - start) - segment count
  localparam int unsigned WIDX_W       = 19;

  // request codes
  typedef enum logic [1:0] {
    REQ_WRITE_SEG  = 2'd0,
    REQ_WRITE_WORD = 2'd1,
    REQ_LOOKUP     = 2'd2,
    REQ_UNUSED     = 2'd3
  } req_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_DELTA = 2'd0,
    ST_ARRAY = 2'd1,
    ST_NONE  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_SEG_COUNT   = 1'b0,
    CFG_GLYPH_WORDS = 1'b1
  } cfg_idx_t;

  // one segment as held in the segment store
  typedef struct packed {
    logic [CODE_W-1:0] lo_code;
    logic [CODE_W-1:0] hi_code;
    logic [CODE_W-1:0] delta;
    logic [CODE_W-1:0] offset;
  } seg_rec_t;

endpackage

/* rtl/cmap_segment_glyph_lookup.sv */
// ----------------------------------------------------------------------------
// cmap_segment_glyph_lookup: character code to glyph index lookup engine
// Holds a format 4 segment table and glyph id array, and translates a code
// by scanning the segments in order, one per cycle, through one compare unit.
// ----------------------------------------------------------------------------
//
//  channel  | ports                                 | handshake
//  ---------+---------------------------------------+--------------------------
//  input    | start, busy, in_*                     | word taken: start & !busy
//  result   | out_valid, out_*                      | one-cycle strobe
//  config   | cfg_we, cfg_index, cfg_wdata          | written when cfg_we high
//
//  Writes of segments or array words give no result. A lookup scans the
//  segments in order; a hit returns by delta or goes on to the index sum,
//  the range check and, for an index in range, the array read. A miss
//  returns after the last segment in use. The scan is paced by the segment
//  store's single registered read port. Reset is synchronous; the stores
//  are not cleared. The receiver cannot stall the one-cycle result.
//
module cmap_segment_glyph_lookup #(
  parameter int unsigned MAX_SEGMENTS      = 256,
  parameter int unsigned GLYPH_ARRAY_DEPTH = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input channel
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           in_req_type,
  input  logic [csgl_pkg::ENTRY_W-1:0]         in_entry_index,
  input  logic [csgl_pkg::CODE_W-1:0]          in_start_code,
  input  logic [csgl_pkg::CODE_W-1:0]          in_end_code,
  input  logic signed [csgl_pkg::CODE_W-1:0]   in_id_delta,
  input  logic [csgl_pkg::CODE_W-1:0]          in_range_offset,
  input  logic [csgl_pkg::CODE_W-1:0]          in_array_word,
  input  logic [csgl_pkg::CODE_W-1:0]          in_char_code,
  // result channel
  output logic                                 out_valid,
  output logic [csgl_pkg::CODE_W-1:0]          out_glyph_index,
  output logic [1:0]                           out_lookup_status,
  output logic [csgl_pkg::SEG_NUM_W-1:0]       out_matched_segment,
  // configuration port
  input  logic                                 cfg_we,
  input  logic [0:0]                           cfg_index,
  input  logic [csgl_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int unsigned SEG_AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned SEG_CW = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned WRD_AW = (GLYPH_ARRAY_DEPTH > 1) ? $clog2(GLYPH_ARRAY_DEPTH) : 1;
  localparam int unsigned WRD_CW = $clog2(GLYPH_ARRAY_DEPTH + 1);
  localparam int unsigned CW     = csgl_pkg::CODE_W;
  localparam int unsigned XW     = csgl_pkg::WIDX_W;

  // one-hot sequencer
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_CALC  = 5'b00100,
    S_CHECK = 5'b01000,
    S_WORD  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [csgl_pkg::SEG_COUNT_W-1:0]  seg_count_r;
  logic [csgl_pkg::WORD_COUNT_W-1:0] glyph_words_r;

  // stores
  csgl_pkg::seg_rec_t seg_mem [MAX_SEGMENTS];
  logic [CW-1:0]      glyph_mem [GLYPH_ARRAY_DEPTH];
  csgl_pkg::seg_rec_t seg_rd_r;
  logic [CW-1:0]      word_rd_r;

  // lookup context
  logic [CW-1:0]     code_r;
  logic [SEG_CW-1:0] nseg_r;
  logic [WRD_CW-1:0] nwords_r;
  logic [SEG_CW-1:0] iss_r, iss_nxt;
  logic [SEG_CW-1:0] cmp_r, cmp_nxt;
  logic              seg_vld_r, seg_vld_nxt;

  // matched segment
  logic [SEG_CW-1:0]       hit_seg_r;
  logic [CW-1:0]           delta_r;
  logic [CW-1:0]           off_r;
  logic [CW-1:0]           diff_r;
  logic signed [XW-1:0]    base_r;
  logic signed [XW-1:0]    widx_r;

  // result register
  logic                               out_valid_r;
  logic [CW-1:0]                      out_glyph_r;
  csgl_pkg::status_t                  out_status_r;
  logic [csgl_pkg::SEG_NUM_W-1:0]     out_seg_r;

  logic          accept;
  logic          hit;
  logic          last;
  logic          out_of_range;
  logic [31:0]   entry32;
  logic [31:0]   nseg32;
  logic [31:0]   nwords32;
  logic [31:0]   hit_seg32;
  logic [CW-1:0] add_a;
  logic [CW-1:0] add_sum;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  // ---- configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_count_r   <= csgl_pkg::SEG_COUNT_W'(1);
      glyph_words_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        csgl_pkg::CFG_SEG_COUNT:   seg_count_r   <= cfg_wdata[csgl_pkg::SEG_COUNT_W-1:0];
        csgl_pkg::CFG_GLYPH_WORDS: glyph_words_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // saturated counts taken at the start of a lookup
  assign entry32  = 32'(in_entry_index);
  assign nseg32   = (32'(seg_count_r) > MAX_SEGMENTS) ? MAX_SEGMENTS : 32'(seg_count_r);
  assign nwords32 = (32'(glyph_words_r) > GLYPH_ARRAY_DEPTH) ? GLYPH_ARRAY_DEPTH
                                                              : 32'(glyph_words_r);

  // ---- segment store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (accept && (in_req_type == csgl_pkg::REQ_WRITE_SEG) && (entry32 < MAX_SEGMENTS)) begin
      seg_mem[entry32[SEG_AW-1:0]] <= '{lo_code: in_start_code, hi_code: in_end_code,
                                         delta: in_id_delta, offset: in_range_offset};
    end
    seg_rd_r <= seg_mem[iss_r[SEG_AW-1:0]];
  end

  // ---- glyph word store
  always_ff @(posedge clk) begin
    if (accept && (in_req_type == csgl_pkg::REQ_WRITE_WORD) &&
        (entry32 < GLYPH_ARRAY_DEPTH)) begin
      glyph_mem[entry32[WRD_AW-1:0]] <= in_array_word;
    end
    if (state_r == S_CHECK) begin
      word_rd_r <= glyph_mem[widx_r[WRD_AW-1:0]];
    end
  end

  // ---- compare unit: does the segment just read cover the code
  assign hit  = seg_vld_r && (code_r >= seg_rd_r.lo_code) && (code_r <= seg_rd_r.hi_code);
  assign last = seg_vld_r && (cmp_r == (nseg_r - SEG_CW'(1)));

  assign out_of_range = widx_r[XW-1] ||
                        (widx_r[XW-2:0] >= (XW-1)'(nwords_r));

  // glyph adder: code on the delta path, array word on the array path
  assign add_a     = (state_r == S_WORD) ? word_rd_r : code_r;
  assign add_sum   = add_a + ((state_r == S_WORD) ? delta_r : seg_rd_r.delta);
  assign hit_seg32 = 32'(hit_seg_r);

  // ---- sequencer next state
  always_comb begin
    state_nxt   = state_r;
    iss_nxt     = iss_r;
    cmp_nxt     = cmp_r;
    seg_vld_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        iss_nxt = '0;
        if (accept && (in_req_type == csgl_pkg::REQ_LOOKUP) && (nseg32 != 0)) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        iss_nxt     = iss_r + SEG_CW'(1);
        cmp_nxt     = iss_r;
        seg_vld_nxt = (iss_r < nseg_r);
        if (hit) begin
          seg_vld_nxt = 1'b0;
          state_nxt   = (seg_rd_r.offset == '0) ? S_IDLE : S_CALC;
        end else if (last) begin
          seg_vld_nxt = 1'b0;
          state_nxt   = S_IDLE;
        end
      end
      S_CALC:  state_nxt = S_CHECK;
      S_CHECK: state_nxt = out_of_range ? S_IDLE : S_WORD;
      S_WORD:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---- control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      seg_vld_r <= 1'b0;
      iss_r     <= '0;
      cmp_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      seg_vld_r <= seg_vld_nxt;
      iss_r     <= iss_nxt;
      cmp_r     <= cmp_nxt;
    end
  end

  // ---- lookup context and index arithmetic
  always_ff @(posedge clk) begin
    if (accept) begin
      code_r   <= in_char_code;
      nseg_r   <= nseg32[SEG_CW-1:0];
      nwords_r <= nwords32[WRD_CW-1:0];
    end
    if ((state_r == S_SCAN) && hit) begin
      hit_seg_r <= cmp_r;
      delta_r   <= seg_rd_r.delta;
      off_r     <= seg_rd_r.offset;
      diff_r    <= code_r - seg_rd_r.lo_code;
      base_r    <= XW'(cmp_r) - XW'(nseg_r);
    end
    if (state_r == S_CALC) begin
      widx_r <= XW'(diff_r) + XW'(off_r[CW-1:1]) + base_r;
    end
  end

  // ---- result register, one-cycle strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept && (in_req_type == csgl_pkg::REQ_LOOKUP) && (nseg32 == 0)) begin
            out_valid_r <= 1'b1;
          end
        end
        S_SCAN:  out_valid_r <= (hit && (seg_rd_r.offset == '0)) || (!hit && last);
        S_CHECK: out_valid_r <= out_of_range;
        S_WORD:  out_valid_r <= 1'b1;
        default: out_valid_r <= 1'b0;
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        out_glyph_r  <= '0;
        out_status_r <= csgl_pkg::ST_NONE;
        out_seg_r    <= '0;
      end
      S_SCAN: begin
        if (hit) begin
          out_glyph_r  <= add_sum;
          out_status_r <= csgl_pkg::ST_DELTA;
          out_seg_r    <= csgl_pkg::SEG_NUM_W'(cmp_r);
        end else begin
          out_glyph_r  <= '0;
          out_status_r <= csgl_pkg::ST_NONE;
          out_seg_r    <= '0;
        end
      end
      S_CHECK: begin
        out_glyph_r  <= '0;
        out_status_r <= csgl_pkg::ST_RANGE;
        out_seg_r    <= hit_seg32[csgl_pkg::SEG_NUM_W-1:0];
      end
      S_WORD: begin
        out_glyph_r  <= (word_rd_r == '0) ? '0 : add_sum;
        out_status_r <= csgl_pkg::ST_ARRAY;
        out_seg_r    <= hit_seg32[csgl_pkg::SEG_NUM_W-1:0];
      end
      default: ;
    endcase
  end

  assign out_valid           = out_valid_r;
  assign out_glyph_index     = out_glyph_r;
  assign out_lookup_status   = out_status_r;
  assign out_matched_segment = out_seg_r;

  // ---- assertions
  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while a lookup is still running");

  a_lookup_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_req_type == csgl_pkg::REQ_LOOKUP)) |=> (busy || out_valid))
    else $error("accepted lookup neither started nor answered");

  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_req_type != csgl_pkg::REQ_LOOKUP)) |=> !out_valid)
    else $error("write produced a result");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SCAN) && seg_vld_r) |-> (cmp_r < nseg_r))
    else $error("scan compared a segment beyond the count in use");

endmodule

/* test/csgl_glyph_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csgl_glyph_checker: result checker for the cmap segment glyph lookup
// Watches the command, result and register ports, keeps its own copy of the
// segment table, glyph array and register values, works out the glyph for
// every lookup word taken and compares each result strobe with the oldest
// outstanding expectation.
// ----------------------------------------------------------------------------
module csgl_glyph_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic                               busy,
  input  logic [1:0]                         in_req_type,
  input  logic [csgl_pkg::ENTRY_W-1:0]       in_entry_index,
  input  logic [csgl_pkg::CODE_W-1:0]        in_start_code,
  input  logic [csgl_pkg::CODE_W-1:0]        in_end_code,
  input  logic [csgl_pkg::CODE_W-1:0]        in_id_delta,
  input  logic [csgl_pkg::CODE_W-1:0]        in_range_offset,
  input  logic [csgl_pkg::CODE_W-1:0]        in_array_word,
  input  logic [csgl_pkg::CODE_W-1:0]        in_char_code,
  input  logic                               out_valid,
  input  logic [csgl_pkg::CODE_W-1:0]        out_glyph_index,
  input  logic [1:0]                         out_lookup_status,
  input  logic [csgl_pkg::SEG_NUM_W-1:0]     out_matched_segment,
  input  logic                               cfg_we,
  input  logic [0:0]                         cfg_index,
  input  logic [csgl_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output int                                 mismatches,
  output int                                 outstanding
);

  localparam int SEG_DEPTH    = 256;
  localparam int WORD_DEPTH   = 4096;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [csgl_pkg::CODE_W-1:0]    code;
    logic [csgl_pkg::CODE_W-1:0]    glyph;
    csgl_pkg::status_t              status;
    logic [csgl_pkg::SEG_NUM_W-1:0] seg;
  } glyph_result_t;

  csgl_pkg::seg_rec_t                seg_tab [SEG_DEPTH];
  logic [csgl_pkg::CODE_W-1:0]       word_tab [WORD_DEPTH];
  logic [csgl_pkg::SEG_COUNT_W-1:0]  seg_count_q;
  logic [csgl_pkg::WORD_COUNT_W-1:0] word_count_q;
  glyph_result_t                     glyph_queue [$];
  glyph_result_t                     oldest;

  // first covering segment decides; counts above the store sizes saturate
  function automatic glyph_result_t translate_code(logic [csgl_pkg::CODE_W-1:0] code);
    glyph_result_t r;
    int nseg;
    int nwords;
    int widx;
    logic [csgl_pkg::CODE_W-1:0] gword;
    nseg   = (seg_count_q > SEG_DEPTH) ? SEG_DEPTH : int'(seg_count_q);
    nwords = (word_count_q > WORD_DEPTH) ? WORD_DEPTH : int'(word_count_q);
    r.code   = code;
    r.glyph  = '0;
    r.status = csgl_pkg::ST_NONE;
    r.seg    = '0;
    for (int s = 0; s < nseg; s++) begin
      if (code >= seg_tab[s].lo_code && code <= seg_tab[s].hi_code) begin
        r.seg = 8'(s);
        if (seg_tab[s].offset == '0) begin
          r.glyph  = code + seg_tab[s].delta;
          r.status = csgl_pkg::ST_DELTA;
        end else begin
          // offset counts in bytes from the segment's own offset entry
          widx = s + int'(seg_tab[s].offset >> 1)
                 + int'(code - seg_tab[s].lo_code) - nseg;
          if (widx < 0 || widx >= nwords) begin
            r.status = csgl_pkg::ST_RANGE;
          end else begin
            gword    = word_tab[widx];
            r.glyph  = (gword == '0) ? '0 : gword + seg_tab[s].delta;
            r.status = csgl_pkg::ST_ARRAY;
          end
        end
        return r;
      end
    end
    return r;
  endfunction

  task automatic note_failure(string what);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // result compare first: a strobe always belongs to an older lookup
  always @(posedge clk) begin
    if (!rst_n) begin
      seg_count_q  = 9'd1;
      word_count_q = '0;
      glyph_queue.delete();
    end else begin
      if (out_valid) begin
        if (glyph_queue.size() == 0) begin
          note_failure($sformatf("unexpected result glyph %h status %0d segment %0d",
                                 out_glyph_index, out_lookup_status, out_matched_segment));
        end else begin
          oldest = glyph_queue.pop_front();
          if (out_glyph_index !== oldest.glyph || out_lookup_status !== oldest.status ||
              out_matched_segment !== oldest.seg)
            note_failure($sformatf(
              "code %h: expected glyph %h %s seg %0d, got glyph %h status %0d seg %0d",
              oldest.code, oldest.glyph, oldest.status.name(), oldest.seg,
              out_glyph_index, out_lookup_status, out_matched_segment));
        end
      end

      if (cfg_we) begin
        if (cfg_index == csgl_pkg::CFG_SEG_COUNT)
          seg_count_q = cfg_wdata[csgl_pkg::SEG_COUNT_W-1:0];
        else
          word_count_q = cfg_wdata[csgl_pkg::WORD_COUNT_W-1:0];
      end

      // word taken: update the tables or queue the expected glyph
      if (start && !busy) begin
        case (csgl_pkg::req_t'(in_req_type))
          csgl_pkg::REQ_WRITE_SEG: begin
            if (in_entry_index < SEG_DEPTH)
              seg_tab[in_entry_index[7:0]] = '{lo_code: in_start_code, hi_code: in_end_code,
                                               delta: in_id_delta, offset: in_range_offset};
          end
          csgl_pkg::REQ_WRITE_WORD: word_tab[in_entry_index] = in_array_word;
          csgl_pkg::REQ_LOOKUP:     glyph_queue = {glyph_queue, translate_code(in_char_code)};
          default: ;
        endcase
      end
    end
    outstanding <= glyph_queue.size();
  end

endmodule

/* test/tb_cmap_segment_glyph_lookup.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cmap_segment_glyph_lookup: testbench for the cmap segment glyph lookup
// Drives segment, glyph array and lookup words with random gaps over several
// table sizes and register settings, extremes included, and leaves all
// result checking to the checker instance beside the block.
// ----------------------------------------------------------------------------
module tb_cmap_segment_glyph_lookup;

  localparam int SEG_DEPTH    = 256;
  localparam int WORD_DEPTH   = 4096;
  localparam int DRAIN_CYCLES = 270;
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int PHASES       = 8;

  typedef struct packed {
    csgl_pkg::req_t               req;
    logic [csgl_pkg::ENTRY_W-1:0] idx;
    logic [csgl_pkg::CODE_W-1:0]  lo;
    logic [csgl_pkg::CODE_W-1:0]  hi;
    logic [csgl_pkg::CODE_W-1:0]  delta;
    logic [csgl_pkg::CODE_W-1:0]  off;
    logic [csgl_pkg::CODE_W-1:0]  word;
    logic [csgl_pkg::CODE_W-1:0]  code;
  } cmap_req_t;

  logic                              clk;
  logic                              rst_n           = 1'b0;
  logic                              start           = 1'b0;
  logic                              busy;
  logic [1:0]                        in_req_type     = '0;
  logic [csgl_pkg::ENTRY_W-1:0]      in_entry_index  = '0;
  logic [csgl_pkg::CODE_W-1:0]       in_start_code   = '0;
  logic [csgl_pkg::CODE_W-1:0]       in_end_code     = '0;
  logic [csgl_pkg::CODE_W-1:0]       in_id_delta     = '0;
  logic [csgl_pkg::CODE_W-1:0]       in_range_offset = '0;
  logic [csgl_pkg::CODE_W-1:0]       in_array_word   = '0;
  logic [csgl_pkg::CODE_W-1:0]       in_char_code    = '0;
  logic                              out_valid;
  logic [csgl_pkg::CODE_W-1:0]       out_glyph_index;
  logic [1:0]                        out_lookup_status;
  logic [csgl_pkg::SEG_NUM_W-1:0]    out_matched_segment;
  logic                              cfg_we          = 1'b0;
  logic [0:0]                        cfg_index       = '0;
  logic [csgl_pkg::CFG_DATA_W-1:0]   cfg_wdata       = '0;
  int                                mismatches;
  int                                outstanding;

  // stimulus view of the table: which codes hit, which words are loaded
  logic [csgl_pkg::CODE_W-1:0] tab_lo [SEG_DEPTH];
  logic [csgl_pkg::CODE_W-1:0] tab_hi [SEG_DEPTH];
  bit                          word_loaded [WORD_DEPTH];
  int                          active_segs  = 1;
  int                          active_words = 0;

  // per phase: segment count, word count, random words, sender idle percent
  int plan_segs  [PHASES] = '{4, 16, 'h1E03, 40, 511, 0, 8, 2};
  int plan_words [PHASES] = '{64, 256, 0, 128, 200, 13, 300, 32};
  int plan_items [PHASES] = '{180, 150, 90, 120, 60, 30, 250, 120};
  int plan_idle  [PHASES] = '{0, 78, 38, 0, 78, 38, 0, 78};

  cmap_segment_glyph_lookup u_dut (.*);

  csgl_glyph_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- words
  function automatic cmap_req_t noise_req();
    cmap_req_t w;
    w.req   = csgl_pkg::req_t'($urandom_range(3));
    w.idx   = 12'($urandom);
    w.lo    = 16'($urandom);
    w.hi    = 16'($urandom);
    w.delta = 16'($urandom);
    w.off   = 16'($urandom);
    w.word  = 16'($urandom);
    w.code  = 16'($urandom);
    return w;
  endfunction

  function automatic cmap_req_t seg_req(int idx,
                                        logic [csgl_pkg::CODE_W-1:0] lo,
                                        logic [csgl_pkg::CODE_W-1:0] hi,
                                        logic [csgl_pkg::CODE_W-1:0] delta,
                                        logic [csgl_pkg::CODE_W-1:0] off);
    cmap_req_t w;
    w       = noise_req();
    w.req   = csgl_pkg::REQ_WRITE_SEG;
    w.idx   = 12'(idx);
    w.lo    = lo;
    w.hi    = hi;
    w.delta = delta;
    w.off   = off;
    return w;
  endfunction

  function automatic cmap_req_t glyph_req(int idx, logic [csgl_pkg::CODE_W-1:0] value);
    cmap_req_t w;
    w      = noise_req();
    w.req  = csgl_pkg::REQ_WRITE_WORD;
    w.idx  = 12'(idx);
    w.word = value;
    return w;
  endfunction

  function automatic cmap_req_t lookup_req(logic [csgl_pkg::CODE_W-1:0] code);
    cmap_req_t w;
    w      = noise_req();
    w.req  = csgl_pkg::REQ_LOOKUP;
    w.code = code;
    return w;
  endfunction

  // mostly short segments, mostly by delta or with offsets inside the loaded array
  function automatic cmap_req_t random_segment(int s);
    cmap_req_t w;
    int pick;
    int span;
    int base;
    int off;
    w    = seg_req(s, '0, '0, 16'($urandom), '0);
    pick = $urandom_range(99);
    span = $urandom_range(31);
    if (pick < 8) begin
      // inverted: end below start
      w.lo = 16'($urandom_range(65535, 1));
      w.hi = 16'($urandom_range(w.lo - 1));
    end else if (pick < 12) begin
      w.lo = '0;
      w.hi = 16'hFFFF;
    end else begin
      w.lo = 16'($urandom_range(65535 - span));
      w.hi = w.lo + 16'(span);
    end
    pick = $urandom_range(99);
    if (pick < 40) begin
      w.off = '0;
    end else if (pick < 80) begin
      base  = (active_words > 0) ? $urandom_range(active_words - 1) : $urandom_range(15);
      off   = 2 * (base - s + active_segs) + $urandom_range(1);
      w.off = (off >= 1 && off <= 65535) ? 16'(off) : 16'($urandom_range(65535, 1));
    end else if (pick < 88) begin
      // small offsets can give a negative array index
      w.off = 16'($urandom_range(2 * active_segs + 1, 1));
    end else begin
      w.off = 16'($urandom);
    end
    return w;
  endfunction

  function automatic cmap_req_t random_lookup();
    int s;
    int pick;
    int reach;
    logic [csgl_pkg::CODE_W-1:0] code;
    pick = $urandom_range(99);
    code = 16'($urandom);
    if (active_segs > 0 && pick < 75) begin
      s = $urandom_range(active_segs - 1);
      if (tab_hi[s] >= tab_lo[s]) begin
        reach = tab_hi[s] - tab_lo[s];
        if (reach > 64) reach = 64;
        code = tab_lo[s] + 16'($urandom_range(reach));
        if (pick < 10)      code = tab_lo[s] - 16'd1;
        else if (pick < 20) code = tab_hi[s] + 16'd1;
      end
    end
    return lookup_req(code);
  endfunction

  function automatic cmap_req_t random_item();
    cmap_req_t w;
    int pick;
    int sub;
    pick = $urandom_range(99);
    sub  = $urandom_range(99);
    if (pick < 68) begin
      w = random_lookup();
    end else if (pick < 80) begin
      if (sub < 10) begin
        w     = random_segment(0);
        w.idx = 12'($urandom_range(4095, SEG_DEPTH));
      end else if (active_segs > 0 && sub < 85) begin
        w = random_segment($urandom_range(active_segs - 1));
      end else begin
        w = random_segment($urandom_range(SEG_DEPTH - 1));
      end
    end else if (pick < 95) begin
      w = glyph_req((sub < 70 && active_words > 0) ? $urandom_range(active_words - 1)
                                                    : $urandom_range(WORD_DEPTH - 1),
                    ($urandom_range(9) == 0) ? '0 : 16'($urandom));
    end else begin
      w     = noise_req();
      w.req = csgl_pkg::REQ_UNUSED;
    end
    return w;
  endfunction

  // ------------------------------------------------------------- drivers
  task automatic idle_cycle();
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic hold_off(int pct);
    while ($urandom_range(99) < pct) idle_cycle();
  endtask

  // start stays high straight into the next word when there is no gap
  task automatic send(cmap_req_t w);
    start           <= 1'b1;
    in_req_type     <= w.req;
    in_entry_index  <= w.idx;
    in_start_code   <= w.lo;
    in_end_code     <= w.hi;
    in_id_delta     <= w.delta;
    in_range_offset <= w.off;
    in_array_word   <= w.word;
    in_char_code    <= w.code;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (w.req == csgl_pkg::REQ_WRITE_SEG && w.idx < SEG_DEPTH) begin
      tab_lo[w.idx] = w.lo;
      tab_hi[w.idx] = w.hi;
    end
    if (w.req == csgl_pkg::REQ_WRITE_WORD) word_loaded[w.idx] = 1'b1;
  endtask

  // idle first so the count already holds the last word taken
  task automatic drain_results();
    idle_cycle();
    while (outstanding != 0 || busy) idle_cycle();
  endtask

  task automatic set_table_config(int segs, int words);
    drain_results();
    repeat (DRAIN_CYCLES) idle_cycle();
    cfg_we    <= 1'b1;
    cfg_index <= csgl_pkg::CFG_SEG_COUNT;
    cfg_wdata <= 13'(segs);
    @(posedge clk);
    cfg_index <= csgl_pkg::CFG_GLYPH_WORDS;
    cfg_wdata <= 13'(words);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    active_segs  = ((segs & 'h1FF) > SEG_DEPTH) ? SEG_DEPTH : (segs & 'h1FF);
    active_words = ((words & 'h1FFF) > WORD_DEPTH) ? WORD_DEPTH : (words & 'h1FFF);
  endtask

  // fresh segments, then any words below the count not yet loaded, then random items
  task automatic run_phase(int segs, int words, int items, int pct);
    set_table_config(segs, words);
    for (int s = 0; s < active_segs; s++) begin
      hold_off(pct);
      send(random_segment(s));
    end
    for (int i = 0; i < active_words; i++) begin
      if (!word_loaded[i]) begin
        hold_off(pct);
        send(glyph_req(i, ($urandom_range(9) == 0) ? '0 : 16'($urandom)));
      end
    end
    for (int n = 0; n < items; n++) begin
      hold_off(pct);
      if (n == items / 2) drain_results();
      send(random_item());
    end
  endtask

  // ------------------------------------------------------------ directed
  task automatic directed_checks();
    cmap_req_t w;
    logic [csgl_pkg::CODE_W-1:0] codes [9];
    codes = '{16'h0041, 16'h005A, 16'h0000, 16'h0001, 16'h0002,
              16'h0003, 16'h0004, 16'hFFFF, 16'h0040};
    // segment 0 by delta, segment 1 covers everything through the array
    send(seg_req(0, 16'h0041, 16'h005A, 16'hFFE3, 16'h0000));
    send(seg_req(1, 16'h0000, 16'hFFFF, 16'h7FFF, 16'h0003));
    send(glyph_req(0, 16'h0000));
    send(glyph_req(1, 16'hFFFF));
    send(glyph_req(2, 16'h8001));
    send(glyph_req(3, 16'h0001));
    send(glyph_req(4095, 16'hFFFF));
    // segment writes past the store are dropped
    send(seg_req(4095, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send(seg_req(SEG_DEPTH, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000));
    w       = seg_req(4095, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    w.req   = csgl_pkg::REQ_UNUSED;
    w.word  = 16'hFFFF;
    w.code  = 16'hFFFF;
    send(w);
    set_table_config(2, 4);
    foreach (codes[i]) send(lookup_req(codes[i]));
    // negative array index, then an inverted segment that covers nothing
    send(seg_req(0, 16'h0100, 16'h01FF, 16'h8000, 16'h0001));
    send(lookup_req(16'h0100));
    send(seg_req(0, 16'h0200, 16'h01FF, 16'h0000, 16'h0000));
    send(lookup_req(16'h0200));
    // word count above the array depth: codes past the last word are out of range
    set_table_config(2, 8191);
    send(lookup_req(16'h0FFF));
    send(lookup_req(16'h1000));
    send(lookup_req(16'h0003));
    // no segments in use
    set_table_config(0, 4);
    send(lookup_req(16'h0041));
  endtask

  // -------------------------------------------------------------- sequence
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    directed_checks();
    for (int p = 0; p < PHASES; p++)
      run_phase(plan_segs[p], plan_words[p], plan_items[p], plan_idle[p]);
    drain_results();
    repeat (DRAIN_CYCLES) idle_cycle();
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

endmodule
